// File: rtl/ccs_pkg.sv
// Shared types and constants for the corridor centering steer block.
package ccs_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ANG_W = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [14:0] PI_Q12 = 15'sd12868;
    localparam logic signed [14:0] HALF_PI_Q12 = 15'sd6434;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIN     = 3'd0,
        REG_COS     = 3'd1,
        REG_SPACING = 3'd2,
        REG_GTHETA  = 3'd3,
        REG_GX      = 3'd4,
        REG_STEPMAX = 3'd5,
        REG_FWD     = 3'd6
    } t_cfg_idx;

    function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            default: v = ANG_W'(64'sd1 <<< (24 - i));
        endcase
        return v;
    endfunction

endpackage

// File: rtl/corridor_centering_steer_top.sv
// Corridor centering steer: geometry, pipelined CORDIC heading and steering nudge.
//
//  Channel  Direction  Handshake              Word
//  in       input      i_valid / o_stall      left_dist, right_dist
//  out      output     o_valid / i_stall      heading_err, center_err, steer_nudge, drive_cmd
//  cfg      input      i_cfg_valid / o_cfg_ready  register index, data
//
//  One word per cycle while the output is not stalled.
//  Reset is synchronous; configuration registers return to their defaults, pipeline valids clear.
//  A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module corridor_centering_steer_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int DIST_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [11:0]                     i_left_dist,
    input  logic [11:0]                     i_right_dist,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [14:0]              o_heading_err,
    output logic signed [15:0]              o_center_err,
    output logic signed [13:0]              o_steer_nudge,
    output logic signed [15:0]              o_drive_cmd,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ccs_pkg::*;

    localparam int NST = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int VW = 33;
    localparam logic [11:0] DMASK = 12'((64'd1 << DIST_BITS) - 64'd1);

    logic [14:0] r_sin, r_cos;
    logic [9:0]  r_spacing;
    logic [15:0] r_gtheta, r_gx;
    logic [12:0] r_stepmax;
    logic signed [15:0] r_fwd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin <= 15'd16384;
            r_cos <= 15'd28378;
            r_spacing <= 10'd100;
            r_gtheta <= 16'd3277;
            r_gx <= 16'd1966;
            r_stepmax <= 13'd1024;
            r_fwd <= 16'sd6554;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_SIN:     r_sin <= i_cfg_data[14:0];
                REG_COS:     r_cos <= i_cfg_data[14:0];
                REG_SPACING: r_spacing <= i_cfg_data[9:0];
                REG_GTHETA:  r_gtheta <= i_cfg_data;
                REG_GX:      r_gx <= i_cfg_data;
                REG_STEPMAX: r_stepmax <= i_cfg_data[12:0];
                REG_FWD:     r_fwd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    // stage 0: masked inputs
    logic r0_v;
    logic [11:0] r0_l, r0_r;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (adv) r0_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_l <= i_left_dist & DMASK;
            r0_r <= i_right_dist & DMASK;
        end
    end

    // stage 1: products
    logic r1_v;
    logic signed [VW-1:0] r1_x, r1_y;
    logic signed [31:0] r1_c;
    logic signed [VW-1:0] n1_x, n1_y;
    logic signed [31:0] n1_c;
    always_comb begin
        n1_x = VW'({r_spacing, 15'd0}) + VW'(({1'b0, r0_l} + {1'b0, r0_r}) * r_sin);
        n1_y = -(VW'($signed({1'b0, r0_r}) - $signed({1'b0, r0_l})) * $signed({1'b0, r_cos}));
        n1_c = (32'($signed({1'b0, r0_l})) - 32'($signed({1'b0, r0_r})))
               * $signed({1'b0, r_sin}) + 32'sd2048;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (adv) r1_v <= r0_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_x <= n1_x;
            r1_y <= n1_y;
            r1_c <= n1_c;
        end
    end

    // CORDIC chain
    logic                 r_cv [NST+1];
    logic signed [VW:0]   r_cx [NST+1];
    logic signed [VW:0]   r_cy [NST+1];
    logic signed [ANG_W-1:0] r_cz [NST+1];
    logic                 r_cze [NST+1];
    logic                 r_cyneg [NST+1];
    logic signed [16:0]   r_cc [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv[0] <= 1'b0;
        else if (adv) r_cv[0] <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0] <= (VW+1)'(r1_x);
            r_cy[0] <= (VW+1)'(r1_y);
            r_cz[0] <= '0;
            r_cze[0] <= (r1_x == '0);
            r_cyneg[0] <= r1_y > 0;
            if ((r1_c >>> 12) > 32'sd32767) r_cc[0] <= 17'sd32767;
            else if ((r1_c >>> 12) < -32'sd32768) r_cc[0] <= -17'sd32768;
            else r_cc[0] <= 17'(r1_c >>> 12);
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[g+1] <= 1'b0;
            else if (adv) r_cv[g+1] <= r_cv[g];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cze[g+1] <= r_cze[g];
                r_cyneg[g+1] <= r_cyneg[g];
                r_cc[g+1] <= r_cc[g];
                if (r_cy[g] > 0) begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] + atan_q24(g);
                end else begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] - atan_q24(g);
                end
            end
        end
    end

    // heading stage: atan(-along / across) already equals atan2(across, along) - pi/2
    logic r2_v;
    logic signed [14:0] r2_h;
    logic signed [15:0] r2_c;
    logic signed [ANG_W-1:0] n2_z;
    logic signed [15:0] n2_h;
    always_comb begin
        n2_z = (r_cz[NST] + ANG_W'(2048)) >>> 12;
        if (r_cze[NST]) n2_h = r_cyneg[NST] ? 16'(HALF_PI_Q12) : -16'(HALF_PI_Q12);
        else n2_h = 16'(n2_z);
        if (n2_h > 16'(PI_Q12)) n2_h = n2_h - 16'(2 * PI_Q12);
        if (n2_h <= -16'(PI_Q12)) n2_h = n2_h + 16'(2 * PI_Q12);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (adv) r2_v <= r_cv[NST];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_h <= n2_h[14:0];
            r2_c <= r_cc[NST][15:0];
        end
    end

    // gain products
    logic r3_v;
    logic signed [14:0] r3_h;
    logic signed [15:0] r3_c;
    logic signed [31:0] r3_pt;
    logic signed [32:0] r3_px;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (adv) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_h <= r2_h;
            r3_c <= r2_c;
            r3_pt <= 32'($signed({1'b0, r_gtheta}) * r2_h);
            r3_px <= 33'($signed({1'b0, r_gx}) * r2_c);
        end
    end

    // sum, round, saturate
    logic signed [38:0] n4_s;
    logic signed [38:0] n4_r;
    logic signed [13:0] n4_n;
    always_comb begin
        n4_s = 39'(r3_pt) + (39'(r3_px) <<< 4) + 39'sd2048;
        n4_r = n4_s >>> 12;
        if (n4_r > 39'($signed({1'b0, r_stepmax}))) n4_n = 14'($signed({1'b0, r_stepmax}));
        else if (n4_r < -39'($signed({1'b0, r_stepmax})))
            n4_n = -14'($signed({1'b0, r_stepmax}));
        else n4_n = n4_r[13:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_heading_err <= r3_h;
            o_center_err <= r3_c;
            o_steer_nudge <= n4_n;
            o_drive_cmd <= r_fwd;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_steer_nudge))
        else $error("output word changed under stall");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading_err <= PI_Q12 && o_heading_err > -PI_Q12)
        else $error("heading out of range");
    a_nudge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_steer_nudge <= 14'($signed({1'b0, r_stepmax}))
                    && o_steer_nudge >= -14'($signed({1'b0, r_stepmax})))
        else $error("nudge exceeds limit");
endmodule
